>>> design/mbet_pkg.sv
// shared types and constants for the mandelbrot escape-time block
`timescale 1ns / 1ps
package mbet_pkg;

  localparam int WORD_W  = 32;
  localparam int ACC_W   = 96;
  localparam int LEVEL_W = 16;
  localparam int LIMIT_W = 16;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 32;

  typedef enum logic [IDX_W-1:0] {
    REG_ITER_LIMIT  = 3'd0,
    REG_ZOOM_SCALE  = 3'd1,
    REG_OFFSET_REAL = 3'd2,
    REG_OFFSET_IMAG = 3'd3,
    REG_COLUMN_RECIP = 3'd4,
    REG_ROW_RECIP   = 3'd5,
    REG_ASPECT      = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]        iteration_limit;
    logic signed [31:0] zoom_scale;
    logic signed [31:0] offset_real;
    logic signed [31:0] offset_imag;
    logic [28:0]        column_recip;
    logic [28:0]        row_recip;
    logic [30:0]        aspect;
  } cfg_t;

  // one strobe per lane operation, driven by the sequencer
  typedef struct packed {
    logic c_col;
    logic c_asp;
    logic c_half;
    logic c_zoom;
    logic c_load;
    logic it_mul;
    logic it_add;
    logic it_sq;
    logic it_upd;
    logic div_load;
    logic div_step;
  } lane_ctrl_t;

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(32'sh7fffffff);
    lo = -ACC_W'(33'sh080000000);
    if (v > hi) begin
      return WORD_W'(hi);
    end else if (v < lo) begin
      return WORD_W'(lo);
    end
    return WORD_W'(v);
  endfunction

endpackage

>>> design/mbet_lane.sv
// one pixel lane: coordinate mapping, escape iteration and level divide
`timescale 1ns / 1ps
module mbet_lane #(
  parameter int COL_W     = 13,
  parameter int FRAC_BITS = 28
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mbet_pkg::lane_ctrl_t     ctrl,
  input  mbet_pkg::cfg_t           cfg,
  input  logic [COL_W-1:0]         column,
  input  logic signed [31:0]       cy,
  output logic                     active,
  output logic [15:0]              level
);
  import mbet_pkg::*;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  logic [COL_W+28:0]         col_prod;
  logic signed [WORD_W-1:0]  t, u, cx, zx, zy, nx, ny, cx_new;
  logic signed [63:0]        p1, p2, pxx, pyy, pxy;
  logic [63:0]               sxx, syy, mag;
  logic                      in_set;
  logic [15:0]               count, quo;
  logic [16:0]               rem, rem_sh;

  assign col_prod = column * cfg.column_recip;
  assign cx_new   = sat_word(ACC_W'(p2 >>> FRAC_BITS) + ACC_W'(cfg.offset_real));
  assign mag      = sxx + syy;
  assign in_set   = (mag >> FRAC_BITS) < (64'd4 << FRAC_BITS);
  assign rem_sh   = {rem[15:0], 1'b0};

  always_ff @(posedge clk) begin
    if (ctrl.c_col)  t  <= sat_word(ACC_W'(col_prod));
    if (ctrl.c_asp)  p1 <= t * $signed({1'b0, cfg.aspect});
    if (ctrl.c_half) u  <= sat_word(ACC_W'(p1 >>> FRAC_BITS) - HALF);
    if (ctrl.c_zoom) p2 <= u * cfg.zoom_scale;
    if (ctrl.c_load) begin
      cx    <= cx_new;
      zx    <= cx_new;
      zy    <= cy;
      count <= '0;
    end
    if (ctrl.it_mul) begin
      pxx <= zx * zx;
      pyy <= zy * zy;
      pxy <= zx * zy;
    end
    if (ctrl.it_add) begin
      nx <= sat_word(ACC_W'((pxx - pyy) >>> FRAC_BITS) + ACC_W'(cx));
      ny <= sat_word(ACC_W'(pxy >>> (FRAC_BITS - 1)) + ACC_W'(cy));
    end
    if (ctrl.it_sq) begin
      sxx <= $unsigned(64'(nx) * 64'(nx));
      syy <= $unsigned(64'(ny) * 64'(ny));
    end
    if (ctrl.it_upd && active && in_set) begin
      count <= count + 16'd1;
      zx    <= nx;
      zy    <= ny;
    end
    // restoring divide of count * 2^16 by the limit, one quotient bit a step
    if (ctrl.div_load) begin
      rem <= {1'b0, count};
      quo <= '0;
    end else if (ctrl.div_step) begin
      if (rem_sh >= {1'b0, cfg.iteration_limit}) begin
        rem <= rem_sh - {1'b0, cfg.iteration_limit};
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (ctrl.c_load) begin
      active <= 1'b1;
    end else if (ctrl.it_upd && active && !in_set) begin
      active <= 1'b0;
    end
  end

  assign level = (count == cfg.iteration_limit) ? '0 : quo;

endmodule

>>> design/mandelbrot_escape_time_8_lanes_top.sv
// top level: config registers, sequencer, shared cy path, lanes and result merge
`timescale 1ns / 1ps
// mandelbrot escape-time block, LANES adjacent pixels per beat
//
// s_tdata carries one group: start column and row. m_tdata returns one
// beat of LANES levels in Q0.16, lane 0 in the lowest 16 bits.
// config is written through cfg_wen / cfg_index / cfg_data; the user must do
// so only while idle (unenforced); an index past the register list is ignored.
//
// per beat: setup maps every pixel to c (three multiply steps per
// lane, cy shared), then each iteration runs in all lanes at once
// (products, add/saturate, squares, escape test), then a decision step and
// a bit-serial divide in every lane. the number of iterations run is at
// most iteration_limit, fewer once all lanes escaped; the next group is
// taken once the sequencer is back in idle.
//
// the finished result sits in an output register, so a new group is
// accepted while m_tready is low; the sequencer only waits at its end if
// the previous result is still not taken. reset returns to idle, drops
// m_tvalid and reloads the register defaults (limit 256, scale 3.0).
module mandelbrot_escape_time_8_lanes_top #(
  parameter int LANES      = 8,
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 28
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // start_column, pixel_row, zero fill
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // level_0 .. level_(LANES-1)
  output logic [LANES*16-1:0]                    m_tdata,
  input  logic                                   cfg_wen,
  input  logic [mbet_pkg::IDX_W-1:0]             cfg_index,
  input  logic [mbet_pkg::CFG_W-1:0]             cfg_data
);
  import mbet_pkg::*;

  localparam int COL_W = $clog2((2 ** COORD_BITS) + LANES - 1);
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_ITER  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t                   state;
  cfg_t                     cfg;
  lane_ctrl_t               ctrl;
  logic [3:0]               cnt;
  logic [LIMIT_W-1:0]       it;
  logic [COORD_BITS-1:0]    col0, row;
  logic [COORD_BITS+28:0]   row_prod;
  logic signed [WORD_W-1:0] v, cy;
  logic signed [63:0]       pv;
  logic [LANES-1:0]         lane_act;
  logic [LANES*16-1:0]      levels;
  logic                     finish, out_load;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.iteration_limit <= 16'd256;
      cfg.zoom_scale      <= 32'sd805306368;
      cfg.offset_real     <= '0;
      cfg.offset_imag     <= '0;
      cfg.column_recip    <= 29'd262144;
      cfg.row_recip       <= 29'd262144;
      cfg.aspect          <= 31'd268435456;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_ITER_LIMIT:   cfg.iteration_limit <= cfg_data[15:0];
        REG_ZOOM_SCALE:   cfg.zoom_scale      <= cfg_data;
        REG_OFFSET_REAL:  cfg.offset_real     <= cfg_data;
        REG_OFFSET_IMAG:  cfg.offset_imag     <= cfg_data;
        REG_COLUMN_RECIP: cfg.column_recip    <= cfg_data[28:0];
        REG_ROW_RECIP:    cfg.row_recip       <= cfg_data[28:0];
        REG_ASPECT:       cfg.aspect          <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  // stop before the next iteration once the limit is hit or every lane escaped
  assign finish   = (state == ST_ITER) && (cnt == 4'd0) &&
                    ((it >= cfg.iteration_limit) || !(|lane_act));
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    ctrl          = '0;
    ctrl.c_col    = (state == ST_SETUP) && (cnt == 4'd0);
    ctrl.c_asp    = (state == ST_SETUP) && (cnt == 4'd1);
    ctrl.c_half   = (state == ST_SETUP) && (cnt == 4'd2);
    ctrl.c_zoom   = (state == ST_SETUP) && (cnt == 4'd3);
    ctrl.c_load   = (state == ST_SETUP) && (cnt == 4'd4);
    ctrl.it_mul   = (state == ST_ITER) && (cnt == 4'd0) && !finish;
    ctrl.it_add   = (state == ST_ITER) && (cnt == 4'd1);
    ctrl.it_sq    = (state == ST_ITER) && (cnt == 4'd2);
    ctrl.it_upd   = (state == ST_ITER) && (cnt == 4'd3);
    ctrl.div_load = finish;
    ctrl.div_step = (state == ST_DIV);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      it    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (s_tvalid) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          if (cnt == 4'd4) begin
            cnt   <= '0;
            it    <= '0;
            state <= ST_ITER;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        ST_ITER: begin
          if (finish) begin
            cnt   <= '0;
            state <= ST_DIV;
          end else if (cnt == 4'd3) begin
            cnt <= '0;
            it  <= it + 16'd1;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        ST_DIV: begin
          if (cnt == 4'(LEVEL_W - 1)) begin
            cnt   <= '0;
            state <= ST_DONE;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // input capture and shared imaginary coordinate
  assign row_prod = row * cfg.row_recip;

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      col0 <= s_tdata[COORD_BITS-1:0];
      row  <= s_tdata[2*COORD_BITS-1:COORD_BITS];
    end
    if (ctrl.c_col)  v  <= sat_word(ACC_W'(row_prod) - HALF);
    if (ctrl.c_asp)  pv <= v * cfg.zoom_scale;
    if (ctrl.c_half) cy <= sat_word(ACC_W'(pv >>> FRAC_BITS) + ACC_W'(cfg.offset_imag));
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    mbet_lane #(
      .COL_W     (COL_W),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .cfg    (cfg),
      .column (COL_W'(col0) + COL_W'(k)),
      .cy     (cy),
      .active (lane_act[k]),
      .level  (levels[k*16 +: 16])
    );
  end

  // merge: all lane levels into one output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= levels;
    end
  end

  a_accept_setup: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_SETUP)
    else $error("accepted beat did not start setup");

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_ITER |-> it <= cfg.iteration_limit)
    else $error("iteration count passed the limit");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid && state == ST_IDLE)
    else $error("result not presented after load");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("pending result overwritten");

endmodule
